// ----- rtl/core/oaid_pkg.sv -----
// Package for the ordered array store: sizes, field widths, operation and
// status codes, and the command/status structs between controller and datapath.
// No dependencies.
package oaid_pkg;

    localparam int CAPACITY = 32;
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // store address
    localparam int CW       = $clog2(CAPACITY + 1);                    // entry count

    localparam int KIND_W   = 2;
    localparam int POS_W    = 6;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int IDX_W    = 5;
    localparam int REM_W    = 6;
    localparam int ECNT_W   = 6;

    // compare width wide enough for position, count and addresses
    localparam int CMP_W    = ((POS_W > CW) ? POS_W : CW) + 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ   = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_DELVAL = 2'd3
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef struct packed {
        logic          latch;    // capture request fields
        logic          rd_en;    // read store at addr
        logic [AW-1:0] addr;     // read address, also element index on read-out
        logic          mv;       // read feeds a move/filter write next cycle
        logic          filt;     // drop words equal to the request value
        logic [AW-1:0] dst;      // move destination
        logic          wp_clr;   // restart compaction write pointer
        logic          emit;     // load output register
        logic          elem;     // result carries a stored entry
        logic          last;
        t_status       status;
        logic          commit;   // apply the update to count (and insert word)
    } t_cmd;

    typedef struct packed {
        t_kind            kind;
        logic [POS_W-1:0] pos;
        logic [CW-1:0]    count;
        logic             out_free;
    } t_sts;

endpackage

// ----- rtl/core/oaid_dpath.sv -----
// Datapath of the ordered array store: request registers, word store with
// registered read, move/filter stage, entry count and output register.
// Depends on oaid_pkg.
module oaid_dpath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  oaid_pkg::t_cmd             i_cmd,
    output oaid_pkg::t_sts             o_sts,
    input  logic [oaid_pkg::KIND_W-1:0] i_kind,
    input  logic [oaid_pkg::POS_W-1:0] i_position,
    input  logic signed [oaid_pkg::VAL_W-1:0] i_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [oaid_pkg::STAT_W-1:0] o_status,
    output logic                       o_has_element,
    output logic [oaid_pkg::IDX_W-1:0] o_element_index,
    output logic signed [oaid_pkg::VAL_W-1:0] o_element_value,
    output logic [oaid_pkg::REM_W-1:0] o_removed,
    output logic [oaid_pkg::ECNT_W-1:0] o_entry_count,
    output logic                       o_last
);
    import oaid_pkg::*;

    logic [VAL_W-1:0] r_mem [CAPACITY];

    t_kind             r_kind;
    logic [POS_W-1:0]  r_pos;
    logic [VAL_W-1:0]  r_value;
    logic [VAL_W-1:0]  r_rdata;
    logic              r_pend;
    logic              r_pend_filt;
    logic [AW-1:0]     r_pend_dst;
    logic [CW-1:0]     r_wp;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [REM_W-1:0]  n_removed;
    logic              keep;
    logic              upd;

    logic              r_ovalid;
    t_status           r_ostatus;
    logic              r_ohas;
    logic [IDX_W-1:0]  r_oidx;
    logic [VAL_W-1:0]  r_oval;
    logic [REM_W-1:0]  r_orem;
    logic [ECNT_W-1:0] r_ocnt;
    logic              r_olast;

    assign keep = r_pend && (!r_pend_filt || (r_rdata != r_value));
    assign upd  = i_cmd.emit && i_cmd.commit;

    // count and removed after the update
    always_comb begin
        n_count   = r_count;
        n_removed = '0;
        if (i_cmd.commit) begin
            unique case (r_kind)
                KIND_INSERT: n_count = r_count + CW'(1);
                KIND_DELETE: begin
                    n_count   = r_count - CW'(1);
                    n_removed = REM_W'(1);
                end
                KIND_DELVAL: begin
                    n_count   = r_wp;
                    n_removed = REM_W'(r_count - r_wp);
                end
                KIND_READ:   n_count = r_count;
            endcase
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (keep) begin
            r_mem[r_pend_filt ? AW'(r_wp) : r_pend_dst] <= r_rdata;
        end else if (upd && (r_kind == KIND_INSERT)) begin
            r_mem[AW'(r_pos)] <= r_value;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[i_cmd.addr];
        end
    end

    // request fields and move stage payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind  <= t_kind'(i_kind);
            r_pos   <= i_position;
            r_value <= i_value;
        end
        r_pend_filt <= i_cmd.filt;
        r_pend_dst  <= i_cmd.dst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_wp     <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_pend <= i_cmd.rd_en && i_cmd.mv;
            if (i_cmd.wp_clr) begin
                r_wp <= '0;
            end else if (keep && r_pend_filt) begin
                r_wp <= r_wp + CW'(1);
            end
            if (upd) begin
                r_count <= n_count;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_olast <= i_cmd.last;
            if (i_cmd.elem) begin
                r_ostatus <= ST_OK;
                r_ohas    <= 1'b1;
                r_oidx    <= IDX_W'(i_cmd.addr);
                r_oval    <= r_rdata;
                r_orem    <= '0;
                r_ocnt    <= ECNT_W'(r_count);
            end else begin
                r_ostatus <= i_cmd.status;
                r_ohas    <= 1'b0;
                r_oidx    <= '0;
                r_oval    <= '0;
                r_orem    <= n_removed;
                r_ocnt    <= ECNT_W'(n_count);
            end
        end
    end

    assign o_sts.kind     = r_kind;
    assign o_sts.pos      = r_pos;
    assign o_sts.count    = r_count;
    assign o_sts.out_free = !r_ovalid || i_out_ready;

    assign o_out_valid     = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_has_element   = r_ohas;
    assign o_element_index = r_oidx;
    assign o_element_value = r_oval;
    assign o_removed       = r_orem;
    assign o_entry_count   = r_ocnt;
    assign o_last          = r_olast;

endmodule

// ----- rtl/core/oaid_ctrl.sv -----
// Controller of the ordered array store: operation sequencing, the loop
// pointer over the store, and result commands. Depends on oaid_pkg.
module oaid_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  oaid_pkg::t_sts i_sts,
    output oaid_pkg::t_cmd o_cmd
);
    import oaid_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_FILTER,
        S_DRAIN,
        S_RD_ISSUE,
        S_RD_EMIT,
        S_EMIT
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_ptr, n_ptr;
    t_status       r_status, n_status;
    logic          r_commit, n_commit;

    logic [CMP_W-1:0] pos_x, cnt_x, ptr_x;
    logic             at_end;

    assign pos_x  = CMP_W'(i_sts.pos);
    assign cnt_x  = CMP_W'(i_sts.count);
    assign ptr_x  = CMP_W'(r_ptr);
    assign at_end = (ptr_x + CMP_W'(1)) == cnt_x;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_status = r_status;
        n_commit = r_commit;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.latch = i_in_valid;
                if (i_in_valid) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.wp_clr = 1'b1;
                n_status     = ST_OK;
                n_commit     = 1'b0;
                n_ptr        = '0;
                unique case (i_sts.kind)
                    KIND_READ: begin
                        n_state = (cnt_x == '0) ? S_EMIT : S_RD_ISSUE;
                    end
                    KIND_INSERT: begin
                        if (pos_x > cnt_x) begin
                            n_status = ST_BADPOS;
                            n_state  = S_EMIT;
                        end else if (cnt_x >= CMP_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_EMIT;
                        end else begin
                            n_commit = 1'b1;
                            if (pos_x == cnt_x) begin
                                n_state = S_EMIT;
                            end else begin
                                n_ptr   = AW'(i_sts.count - CW'(1));
                                n_state = S_SHIFT_UP;
                            end
                        end
                    end
                    KIND_DELETE: begin
                        if (pos_x >= cnt_x) begin
                            n_status = ST_BADPOS;
                            n_state  = S_EMIT;
                        end else begin
                            n_commit = 1'b1;
                            if ((pos_x + CMP_W'(1)) == cnt_x) begin
                                n_state = S_EMIT;
                            end else begin
                                n_ptr   = AW'(pos_x + CMP_W'(1));
                                n_state = S_SHIFT_DN;
                            end
                        end
                    end
                    KIND_DELVAL: begin
                        n_commit = 1'b1;
                        n_state  = (cnt_x == '0) ? S_EMIT : S_FILTER;
                    end
                endcase
            end
            S_SHIFT_UP: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.addr  = r_ptr;
                o_cmd.mv    = 1'b1;
                o_cmd.dst   = r_ptr + AW'(1);
                if (ptr_x == pos_x) n_state = S_DRAIN;
                else                n_ptr   = r_ptr - AW'(1);
            end
            S_SHIFT_DN: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.addr  = r_ptr;
                o_cmd.mv    = 1'b1;
                o_cmd.dst   = r_ptr - AW'(1);
                if (at_end) n_state = S_DRAIN;
                else        n_ptr   = r_ptr + AW'(1);
            end
            S_FILTER: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.addr  = r_ptr;
                o_cmd.mv    = 1'b1;
                o_cmd.filt  = 1'b1;
                if (at_end) n_state = S_DRAIN;
                else        n_ptr   = r_ptr + AW'(1);
            end
            S_DRAIN: begin
                // last move or compare lands in the store this cycle
                n_state = S_EMIT;
            end
            S_RD_ISSUE: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.addr  = r_ptr;
                n_state     = S_RD_EMIT;
            end
            S_RD_EMIT: begin
                o_cmd.addr = r_ptr;
                o_cmd.elem = 1'b1;
                o_cmd.last = at_end;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (at_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = r_ptr + AW'(1);
                        n_state = S_RD_ISSUE;
                    end
                end
            end
            S_EMIT: begin
                o_cmd.status = r_status;
                o_cmd.commit = r_commit;
                o_cmd.last   = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ptr    <= '0;
            r_status <= ST_OK;
            r_commit <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_status <= n_status;
            r_commit <= n_commit;
        end
    end

endmodule

// ----- rtl/core/ordered_array_insert_delete.sv -----
// Top level of the ordered array store: insert, delete at position,
// delete-by-value and read-out over a 32-word ordered list.
// Depends on oaid_pkg, oaid_ctrl and oaid_dpath.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready     | i_kind, i_position, i_value
//  out     | output    | o_out_valid / i_out_ready   | o_status, o_has_element,
//          |           |                             | o_element_index, o_element_value,
//          |           |                             | o_removed, o_entry_count, o_last
//
// One request at a time. Each operation walks the word store through its single read port and
// single write port, one entry at a time:
//   read-out   : one result per stored entry; a single result with no entry when empty
//   insert     : entries from position upward move one place up; no moves for an append or a rejected request
//   delete     : entries above position move one place down; no moves for the last entry or a bad position
//   delete-val : every stored entry is compared and kept entries are compacted; no pass when empty
// Reset clears the entry count and the control state but not the store; store words are written before they are read.
// A stalled output holds the controller in its emit step; a new request is taken as
// soon as the previous one has placed its final transfer in the output register.
module ordered_array_insert_delete (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [oaid_pkg::KIND_W-1:0]           i_kind,
    input  logic [oaid_pkg::POS_W-1:0]            i_position,
    input  logic signed [oaid_pkg::VAL_W-1:0]     i_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [oaid_pkg::STAT_W-1:0]           o_status,
    output logic                                  o_has_element,
    output logic [oaid_pkg::IDX_W-1:0]            o_element_index,
    output logic signed [oaid_pkg::VAL_W-1:0]     o_element_value,
    output logic [oaid_pkg::REM_W-1:0]            o_removed,
    output logic [oaid_pkg::ECNT_W-1:0]           o_entry_count,
    output logic                                  o_last
);
    import oaid_pkg::*;

    // controller -> datapath commands, datapath -> controller status
    t_cmd cmd;
    t_sts sts;

    oaid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // store, entry count, move/filter stage and output register
    oaid_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_kind          (i_kind),
        .i_position      (i_position),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_has_element   (o_has_element),
        .o_element_index (o_element_index),
        .o_element_value (o_element_value),
        .o_removed       (o_removed),
        .o_entry_count   (o_entry_count),
        .o_last          (o_last)
    );

endmodule
